// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
// All uses expect a clock named clk in scope; ASSERT_CLK also an active-low arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked property that is also checked around reset
`define ASSERT_CLK_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/u8cp_pkg.sv =====
// Package for the UTF-8 to CP1251 transcoder: byte codes, lead mapping tables
// and the pair mapping function. No dependencies.
package u8cp_pkg;

	// Lead bytes of two-byte sequences with special handling
	localparam logic [7:0] LEAD_D0 = 8'hD0;
	localparam logic [7:0] LEAD_D1 = 8'hD1;
	localparam logic [7:0] LEAD_D2 = 8'hD2;
	localparam logic [7:0] LEAD_D3 = 8'hD3;
	localparam logic [7:0] LEAD_C2 = 8'hC2;

	// Lead masks
	localparam logic [7:0] MASK_4B = 8'hF0;
	localparam logic [7:0] MASK_3B = 8'hE0;
	localparam logic [7:0] MASK_2B = 8'hC0;

	// Output codes
	localparam logic [7:0] CODE_4B    = 8'd52;  // '4'
	localparam logic [7:0] CODE_3B    = 8'd51;  // '3'
	localparam logic [7:0] CODE_QMARK = 8'd63;  // '?'
	localparam logic [7:0] CODE_D2_90 = 8'd165;
	localparam logic [7:0] CODE_D2_91 = 8'd180;
	localparam logic [7:0] CODE_D2_ANY = 8'd7;
	localparam logic [7:0] CODE_NONE  = 8'd0;

	// Table bases and sizes
	localparam logic [7:0] D0_BASE = 8'd129;
	localparam logic [7:0] D0_SIZE = 8'd63;
	localparam logic [7:0] D1_BASE = 8'd128;
	localparam logic [7:0] D1_SIZE = 8'd62;
	localparam logic [7:0] C2_BASE = 8'd152;
	localparam logic [7:0] C2_SIZE = 8'd36;

	// Second byte 0x81.. after D0
	localparam logic [7:0] D0_MAP [0:62] = '{
		8'd168, 8'd128, 8'd129, 8'd170, 8'd189, 8'd178, 8'd175, 8'd163, 8'd138, 8'd140,
		8'd142, 8'd141, 8'd0,   8'd161, 8'd143, 8'd192, 8'd193, 8'd194, 8'd195, 8'd196,
		8'd197, 8'd198, 8'd199, 8'd200, 8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206,
		8'd207, 8'd208, 8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216,
		8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226,
		8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236,
		8'd237, 8'd238, 8'd239
	};

	// Second byte 0x80.. after D1
	localparam logic [7:0] D1_MAP [0:61] = '{
		8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249,
		8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd0,   8'd184, 8'd144, 8'd131,
		8'd186, 8'd190, 8'd179, 8'd191, 8'd188, 8'd154, 8'd156, 8'd158, 8'd157, 8'd0,
		8'd162, 8'd159, 8'd0,   8'd0,   8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd215,
		8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225,
		8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd233, 8'd234, 8'd235,
		8'd236, 8'd237
	};

	// Second byte 0x98.. after C2
	localparam logic [7:0] C2_MAP [0:35] = '{
		8'd152, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd160, 8'd0,
		8'd0,   8'd0,   8'd164, 8'd0,   8'd166, 8'd167, 8'd0,   8'd169, 8'd0,   8'd171,
		8'd172, 8'd173, 8'd174, 8'd0,   8'd176, 8'd177, 8'd0,   8'd0,   8'd0,   8'd181,
		8'd182, 8'd183, 8'd0,   8'd0,   8'd0,   8'd187
	};

	// Map a completed two-byte pair; CODE_NONE means no output byte
	function automatic logic [7:0] map_pair(input logic [7:0] lead, input logic [7:0] b);
		logic [7:0] d0_idx;
		logic [7:0] d1_idx;
		logic [7:0] c2_idx;
		logic [7:0] res;
		d0_idx = b - D0_BASE;
		d1_idx = b - D1_BASE;
		c2_idx = b - C2_BASE;
		res    = CODE_NONE;
		case (lead)
			LEAD_D0: begin
				if (b >= D0_BASE && d0_idx < D0_SIZE) res = D0_MAP[d0_idx[5:0]];
			end
			LEAD_D1: begin
				if (b >= D1_BASE && d1_idx < D1_SIZE) res = D1_MAP[d1_idx[5:0]];
			end
			LEAD_C2: begin
				if (b >= C2_BASE && c2_idx < C2_SIZE) res = C2_MAP[c2_idx[5:0]];
			end
			LEAD_D2: begin
				if (b == 8'h90)      res = CODE_D2_90;
				else if (b == 8'h91) res = CODE_D2_91;
				else                 res = CODE_D2_ANY;
			end
			LEAD_D3: res = CODE_NONE;
			default: res = CODE_QMARK;
		endcase
		return res;
	endfunction

endpackage

// ===== rtl/core/utf8_to_cp1251_decoder.sv =====
// UTF-8 to CP1251 transcoder, one byte per transaction in each direction.
// Registered output: a byte accepted at an edge shows on m_tdata after that edge.
// Throughput: one input byte per cycle; the single output register refills in the
// cycle it is taken, so m_tready low is the only thing that stalls the input.
// Reset (arst_n low, asynchronous): held lead, skip count and output valid clear.
module utf8_to_cp1251_decoder
	import u8cp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] cp1251_byte
);

	logic [7:0] held_q;
	logic [1:0] skip_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic [7:0] held_d;
	logic [1:0] skip_d;
	logic [7:0] res;
	logic       emit;
	logic       accept;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Per-byte decode and next sequence state
	always_comb begin
		held_d = held_q;
		skip_d = skip_q;
		res    = CODE_NONE;
		emit   = 1'b0;
		if (skip_q != 2'd0) begin
			skip_d = skip_q - 2'd1;
		end else if (held_q != 8'd0) begin
			res    = map_pair(held_q, s_tdata);
			held_d = 8'd0;
			emit   = (res != CODE_NONE);
		end else if (!s_tdata[7]) begin
			res  = s_tdata;
			emit = 1'b1;
		end else if ((s_tdata & MASK_4B) == MASK_4B) begin
			res    = CODE_4B;
			emit   = 1'b1;
			skip_d = 2'd3;
		end else if ((s_tdata & MASK_3B) == MASK_3B) begin
			res    = CODE_3B;
			emit   = 1'b1;
			skip_d = 2'd2;
		end else if ((s_tdata & MASK_2B) == MASK_2B) begin
			held_d = s_tdata;
		end
		// stray continuation bytes fall through with no output
		if (s_tlast) begin
			held_d = 8'd0;
			skip_d = 2'd0;
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'd0;
			skip_q <= 2'd0;
		end else if (accept) begin
			held_q <= held_d;
			skip_q <= skip_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_data_q <= res;
		end
	end

endmodule

// ===== rtl/core/u8cp_checker.sv =====
// Port-level checker for the UTF-8 to CP1251 transcoder, bound to the decoder.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module u8cp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// Stalled output transaction holds
	`ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

	// An empty output stage never blocks the input
	`ASSERT_CLK(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")

	// After end of text, an ASCII byte passes straight through
	`ASSERT_CLK(a_ascii_after_end, (s_tvalid && s_tready && s_tlast) ##1 (s_tvalid && s_tready && !s_tdata[7]) |=> m_tvalid && m_tdata == $past(s_tdata), "ASCII byte after end of text not passed through")

	// Nothing is offered in the first cycle out of reset
	`ASSERT_CLK_RST(a_reset_clear, $rose(arst_n) |-> !m_tvalid, "output valid after reset")

endmodule

bind utf8_to_cp1251_decoder u8cp_checker u_u8cp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
